/* design/bdras_pkg.sv */
// Shared types and constants for the block-decomposed range add / range sum core.
// No dependencies; imported by bdras_elem_ram and block_decomposed_range_add_sum_core.
package bdras_pkg;

  localparam int ELEMENTS   = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int NBLOCKS    = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(ELEMENTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int BLK_W      = $clog2(BLOCK_SIZE);
  localparam int NBLK_W     = $clog2(NBLOCKS);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SUM  = 2'd1,
    OP_ADD  = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  localparam logic KIND_SUM  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] answer;
    logic                     answer_kind;
  } out_item_t;

  // element store write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_PT_RD,
    ST_PT_ADD,
    ST_PT_FIX
  } state_t;

endpackage

/* design/bdras_elem_ram.sv */
// Element store: one write port, one read port, registered read data.
// Depends on bdras_pkg.
module bdras_elem_ram (
  input  logic                          clk,
  input  bdras_pkg::mem_wr_t            wr,
  input  logic [bdras_pkg::IDX_W-1:0]   rd_addr,
  output logic [bdras_pkg::DATA_W-1:0]  rd_data
);
  import bdras_pkg::*;

  logic [DATA_W-1:0] mem [ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/block_decomposed_range_add_sum_core.sv */
// Range add / range sum over 1024 signed 32-bit elements in blocks of 32.
// Point read and load go through the element store; range ops walk partial elements
// through the store and whole blocks through the block registers; one item at a time.
// The walk is set by the element store's single read port, one element per cycle.
// After reset a clearing pass zeroes the element store while busy stays high.
// Results show on out_item for one cycle with out_valid; the receiver cannot stall.
module block_decomposed_range_add_sum_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bdras_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output bdras_pkg::out_item_t  out_item
);
  import bdras_pkg::*;

  // control
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               p_vld_r, p_vld_nxt;

  // latched item and walk
  in_item_t           item_r, item_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [DATA_W-1:0]  acc_r, acc_nxt;
  logic [DATA_W-1:0]  vis_r, vis_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // element read in flight (second half of the partial-element pipeline)
  logic [IDX_W-1:0]   p_addr_r, p_addr_nxt;
  logic [NBLK_W-1:0]  p_blk_r, p_blk_nxt;
  logic [DATA_W-1:0]  p_pend_r, p_pend_nxt;

  // per-block sums and pending adds
  logic [DATA_W-1:0]  bsum_r [NBLOCKS];
  logic [DATA_W-1:0]  pend_r [NBLOCKS];
  logic               bs_we, pd_we;
  logic [NBLK_W-1:0]  bs_idx, pd_idx;
  logic [DATA_W-1:0]  bs_wdata, pd_wdata;

  // element store port
  mem_wr_t            mem_wr;
  logic [IDX_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data;

  // decode
  logic               accept;
  logic [IDX_W-1:0]   last_clamped;
  logic               first_ok;
  logic               in_range;
  logic               whole;
  logic [NBLK_W-1:0]  j_blk;
  logic [NBLK_W-1:0]  pt_blk;
  logic [DATA_W-1:0]  val_u;

  bdras_elem_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign last_clamped = ({1'b0, in_item.last_index} > CNT_W'(ELEMENTS - 1)) ?
                        IDX_W'(ELEMENTS - 1) : in_item.last_index;
  assign first_ok     = {1'b0, in_item.first_index} < CNT_W'(ELEMENTS);

  assign val_u    = item_r.value;
  assign j_blk    = j_r[IDX_W-1:BLK_W];
  assign pt_blk   = item_r.first_index[IDX_W-1:BLK_W];
  assign in_range = j_r <= {1'b0, last_r};
  // aligned block start whose full span lies inside the range
  assign whole    = (j_r[BLK_W-1:0] == '0) &&
                    ((j_r + CNT_W'(BLOCK_SIZE - 1)) <= {1'b0, last_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(ELEMENTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.opcode) inside
            OP_LOAD, OP_READ: state_nxt = first_ok ? ST_PT_RD : ST_IDLE;
            OP_SUM, OP_ADD:   state_nxt = ST_WALK;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (!in_range && !p_vld_r) state_nxt = ST_IDLE;
      end
      ST_PT_RD:  state_nxt = ST_PT_ADD;
      ST_PT_ADD: state_nxt = (item_r.opcode == OP_LOAD) ? ST_PT_FIX : ST_IDLE;
      ST_PT_FIX: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    p_vld_nxt     = 1'b0;
    p_addr_nxt    = p_addr_r;
    p_blk_nxt     = p_blk_r;
    p_pend_nxt    = p_pend_r;
    item_nxt      = item_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    vis_nxt       = vis_r;
    mem_wr        = '0;
    rd_addr       = j_r[IDX_W-1:0];
    bs_we         = 1'b0;
    bs_idx        = j_blk;
    bs_wdata      = '0;
    pd_we         = 1'b0;
    pd_idx        = j_blk;
    pd_wdata      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_r;
        mem_wr.data = '0;
        clr_nxt     = clr_r + 1'b1;
      end

      ST_IDLE: begin
        if (accept) begin
          item_nxt = in_item;
          j_nxt    = {1'b0, in_item.first_index};
          last_nxt = last_clamped;
          acc_nxt  = '0;
          // point read past the end answers zero right away
          if (in_item.opcode == OP_READ && !first_ok) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.answer      = '0;
            out_item_nxt.answer_kind = KIND_READ;
          end
        end
      end

      ST_WALK: begin
        // issue side: whole block through block regs, partial element through the store.
        // A whole block waits while an element transfer is still in flight.
        if (in_range && !(whole && p_vld_r)) begin
          if (whole) begin
            if (item_r.opcode == OP_SUM) begin
              acc_nxt = acc_r + bsum_r[j_blk];
            end else begin
              bs_we    = 1'b1;
              bs_idx   = j_blk;
              bs_wdata = bsum_r[j_blk] + (val_u << BLK_W);
              pd_we    = 1'b1;
              pd_idx   = j_blk;
              pd_wdata = pend_r[j_blk] + val_u;
            end
            j_nxt = j_r + CNT_W'(BLOCK_SIZE);
          end else begin
            rd_addr    = j_r[IDX_W-1:0];
            p_vld_nxt  = 1'b1;
            p_addr_nxt = j_r[IDX_W-1:0];
            p_blk_nxt  = j_blk;
            p_pend_nxt = pend_r[j_blk];
            j_nxt      = j_r + 1'b1;
          end
        end
        // completion side: element data is back from the store
        if (p_vld_r) begin
          if (item_r.opcode == OP_SUM) begin
            acc_nxt = acc_r + rd_data + p_pend_r;
          end else begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = p_addr_r;
            mem_wr.data = rd_data + val_u;
            bs_we       = 1'b1;
            bs_idx      = p_blk_r;
            bs_wdata    = bsum_r[p_blk_r] + val_u;
          end
        end
        if (!in_range && !p_vld_r && item_r.opcode == OP_SUM) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.answer      = acc_r;
          out_item_nxt.answer_kind = KIND_SUM;
        end
      end

      ST_PT_RD: begin
        rd_addr = item_r.first_index;
      end

      ST_PT_ADD: begin
        vis_nxt = rd_data + pend_r[pt_blk];
        if (item_r.opcode == OP_LOAD) begin
          // stored value excludes the block's pending add
          mem_wr.en   = 1'b1;
          mem_wr.addr = item_r.first_index;
          mem_wr.data = val_u - pend_r[pt_blk];
        end else begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.answer      = rd_data + pend_r[pt_blk];
          out_item_nxt.answer_kind = KIND_READ;
        end
      end

      ST_PT_FIX: begin
        bs_we    = 1'b1;
        bs_idx   = pt_blk;
        bs_wdata = bsum_r[pt_blk] + (val_u - vis_r);
      end

      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      for (int i = 0; i < NBLOCKS; i++) begin
        bsum_r[i] <= '0;
        pend_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= p_vld_nxt;
      if (bs_we) begin
        bsum_r[bs_idx] <= bs_wdata;
      end
      if (pd_we) begin
        pend_r[pd_idx] <= pd_wdata;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
    vis_r      <= vis_nxt;
    out_item_r <= out_item_nxt;
    p_addr_r   <= p_addr_nxt;
    p_blk_r    <= p_blk_nxt;
    p_pend_r   <= p_pend_nxt;
  end

endmodule
